// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/cgg_pkg.sv =====
// ----------------------------------------------------------------------------
// cgg_pkg
// shared types and constants of the color gradient generator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cgg_pkg;

  localparam int CHAN_W = 8;
  localparam int ACC_W  = 16;
  localparam int NUM_CH = 3;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [ACC_W-1:0]  acc_t;

  // configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] REG_PATTERN_MODE = 2'd0;

  // pattern modes
  localparam logic MODE_LINE   = 1'b0;
  localparam logic MODE_SQUARE = 1'b1;

  // input word kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_NEXT = 1'b1;

endpackage

// ===== design/cgg_in_if.sv =====
// ----------------------------------------------------------------------------
// cgg_in_if
// input channel: load and next-pixel words
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cgg_in_if;
  import cgg_pkg::*;

  logic  valid;
  logic  ready;
  logic  kind;
  chan_t start_red;
  chan_t start_green;
  chan_t start_blue;
  chan_t end_red;
  chan_t end_green;
  chan_t end_blue;
  chan_t size;

  modport source (
    output valid, kind, start_red, start_green, start_blue,
           end_red, end_green, end_blue, size,
    input  ready
  );

  modport sink (
    input  valid, kind, start_red, start_green, start_blue,
           end_red, end_green, end_blue, size,
    output ready
  );
endinterface

// ===== design/cgg_out_if.sv =====
// ----------------------------------------------------------------------------
// cgg_out_if
// result channel: one pixel word with line and pattern flags
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cgg_out_if;
  import cgg_pkg::*;

  logic  valid;
  logic  ready;
  chan_t pixel_red;
  chan_t pixel_green;
  chan_t pixel_blue;
  logic  end_of_line;
  logic  end_of_pattern;

  modport source (
    output valid, pixel_red, pixel_green, pixel_blue, end_of_line, end_of_pattern,
    input  ready
  );

  modport sink (
    input  valid, pixel_red, pixel_green, pixel_blue, end_of_line, end_of_pattern,
    output ready
  );
endinterface

// ===== design/color_gradient_generator_unit.sv =====
// ----------------------------------------------------------------------------
// color_gradient_generator_unit
// rgb gradient generator in 8.8 fixed point with a shared serial divider
// ----------------------------------------------------------------------------
// usage
//   in_ch carries load words (kind 0: start/end colors and size) and next
//   words (kind 1). a next word with a pattern running yields one pixel word
//   on out_ch; otherwise no word comes out. pattern_mode (apb, byte addr 0)
//   picks a single line or a square of complementary-ended rows; write it
//   only while the block is idle.
// sequencing
//   a next word lands in the output register in the cycle after it is taken;
//   plain pixels follow back to back while out_ch keeps up. a row end in square
//   mode divides for the pixel steps of the three channels, a load for the row
//   steps (line) or row then pixel steps (square), with in_ch not ready. each
//   division is a setup step, 16 quotient bits at one bit a cycle, a write-back.
// reset
//   synchronous, active low: no pattern loaded, line mode, output empty.
// stall
//   while a pixel word waits on out_ch, in_ch stays not ready unless the
//   word is taken in that same cycle; nothing is dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module color_gradient_generator_unit #(
  parameter int unsigned MAX_SIZE = 255
) (
  input  logic                            clk,
  input  logic                            rst_n,
  cgg_in_if.sink                          in_ch,
  cgg_out_if.source                       out_ch,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [cgg_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [cgg_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [cgg_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);
  import cgg_pkg::*;

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SETUP = 2'd1;
  localparam logic [1:0] S_ITER  = 2'd2;
  localparam logic [1:0] S_WRITE = 2'd3;

  // divider jobs
  localparam logic JOB_ROW = 1'b0;  // row steps from start to end color
  localparam logic JOB_PIX = 1'b1;  // pixel steps from row color to its complement

  localparam int DIV_STEPS = ACC_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);
  localparam logic [1:0]       CH_LAST  = 2'(NUM_CH - 1);

  // control state
  logic [1:0]  state_r;
  logic        job_r;
  logic [1:0]  ch_r;
  logic [CNT_W-1:0] cnt_r;
  logic        active_r;
  logic        mode_r;
  logic        out_valid_r;
  chan_t       pix_idx_r;
  chan_t       row_idx_r;
  chan_t       size_r;

  // gradient state
  acc_t        pix_acc_r  [NUM_CH];
  acc_t        pix_step_r [NUM_CH];
  acc_t        row_acc_r  [NUM_CH];
  acc_t        row_step_r [NUM_CH];
  chan_t       end_col_r  [NUM_CH];

  // divider datapath
  acc_t        quo_r;
  chan_t       rem_r;
  logic        neg_r;

  // output word
  chan_t       out_col_r [NUM_CH];
  logic        out_eol_r;
  logic        out_eop_r;

  // ---------------------------------------------------------------- handshakes
  logic in_fire;
  logic out_fire;

  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_ch.valid && out_ch.ready;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.pixel_red      = out_col_r[0];
  assign out_ch.pixel_green    = out_col_r[1];
  assign out_ch.pixel_blue     = out_col_r[2];
  assign out_ch.end_of_line    = out_eol_r;
  assign out_ch.end_of_pattern = out_eop_r;

  // ---------------------------------------------------------------- config port
  logic cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr == REG_PATTERN_MODE) ? {{(CFG_DATA_W-1){1'b0}}, mode_r}
                                                      : '0;

  // ---------------------------------------------------------------- load decode
  chan_t start_col [NUM_CH];
  chan_t end_col   [NUM_CH];
  chan_t size_sat;
  logic  load_active;

  assign start_col[0] = in_ch.start_red;
  assign start_col[1] = in_ch.start_green;
  assign start_col[2] = in_ch.start_blue;
  assign end_col[0]   = in_ch.end_red;
  assign end_col[1]   = in_ch.end_green;
  assign end_col[2]   = in_ch.end_blue;

  // clamp to the configured maximum
  assign size_sat = ({8'h00, in_ch.size} > MAX_SIZE[15:0]) ? MAX_SIZE[7:0] : in_ch.size;

  // a square needs at least one row, a line at least one pixel
  assign load_active = (mode_r == MODE_SQUARE) ? (size_sat[7:1] != 7'd0)
                                               : (size_sat != 8'd0);

  // ---------------------------------------------------------------- pixel decode
  logic [8:0] pix_next;
  logic [8:0] row_next;
  logic       eol;
  logic       last_row;
  logic       eop;
  logic       emit;

  assign pix_next = {1'b0, pix_idx_r} + 9'd1;
  assign row_next = {1'b0, row_idx_r} + 9'd1;
  assign eol      = pix_next >= {1'b0, size_r};
  assign last_row = (mode_r == MODE_LINE) || (row_next >= {2'b00, size_r[7:1]});
  assign eop      = eol && last_row;
  assign emit     = in_fire && (in_ch.kind == KIND_NEXT) && active_r;

  // ---------------------------------------------------------------- divider
  // operands: the dividend is |to - from| in 8.8, the divisor is the size
  chan_t      div_from;
  chan_t      div_to;
  logic       div_neg;
  chan_t      div_mag;
  logic [8:0] rem_sh;
  logic       rem_ge;
  chan_t      rem_nxt;
  acc_t       quo_nxt;
  acc_t       div_res;
  logic [8:0] rem_sub;

  assign div_from = row_acc_r[ch_r][15:8];
  assign div_to   = (job_r == JOB_PIX) ? ~div_from : end_col_r[ch_r];
  assign div_neg  = div_to < div_from;
  assign div_mag  = div_neg ? (div_from - div_to) : (div_to - div_from);

  // one restoring step per cycle, quotient shifts in behind the dividend
  assign rem_sh  = {rem_r, quo_r[15]};
  assign rem_ge  = rem_sh >= {1'b0, size_r};
  assign rem_sub = rem_sh - {1'b0, size_r};
  assign rem_nxt = rem_ge ? rem_sub[7:0] : rem_sh[7:0];
  assign quo_nxt = {quo_r[14:0], rem_ge};

  // truncation toward zero: negate the magnitude quotient
  assign div_res = neg_r ? (~quo_r + 16'd1) : quo_r;

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      job_r       <= JOB_ROW;
      ch_r        <= 2'd0;
      cnt_r       <= '0;
      active_r    <= 1'b0;
      mode_r      <= MODE_LINE;
      out_valid_r <= 1'b0;
      pix_idx_r   <= '0;
      row_idx_r   <= '0;
      size_r      <= '0;
    end else begin
      if (cfg_wr && (cfg_paddr == REG_PATTERN_MODE)) begin
        mode_r <= cfg_pwdata[0];
      end

      // a new pixel word refills the slot that is being emptied
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire && (in_ch.kind == KIND_LOAD)) begin
            size_r    <= size_sat;
            pix_idx_r <= '0;
            row_idx_r <= '0;
            active_r  <= load_active;
            job_r     <= JOB_ROW;
            ch_r      <= 2'd0;
            // steps only matter for a pattern that will run
            if (load_active) begin
              state_r <= S_SETUP;
            end
          end else if (emit) begin
            if (eop) begin
              active_r  <= 1'b0;
              pix_idx_r <= '0;
            end else if (eol) begin
              // row end in square mode: new row needs fresh pixel steps
              pix_idx_r <= '0;
              row_idx_r <= row_next[7:0];
              job_r     <= JOB_PIX;
              ch_r      <= 2'd0;
              state_r   <= S_SETUP;
            end else begin
              pix_idx_r <= pix_next[7:0];
            end
          end
        end
        S_SETUP: begin
          cnt_r   <= '0;
          state_r <= S_ITER;
        end
        S_ITER: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_LAST) begin
            state_r <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (ch_r != CH_LAST) begin
            ch_r    <= ch_r + 2'd1;
            state_r <= S_SETUP;
          end else if ((job_r == JOB_ROW) && (mode_r == MODE_SQUARE)) begin
            // first row of a square
            job_r   <= JOB_PIX;
            ch_r    <= 2'd0;
            state_r <= S_SETUP;
          end else begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && (in_ch.kind == KIND_LOAD)) begin
          for (int c = 0; c < NUM_CH; c++) begin
            row_acc_r[c] <= {start_col[c], 8'h00};
            pix_acc_r[c] <= {start_col[c], 8'h00};
            end_col_r[c] <= end_col[c];
          end
        end else if (emit) begin
          for (int c = 0; c < NUM_CH; c++) begin
            out_col_r[c] <= pix_acc_r[c][15:8];
            pix_acc_r[c] <= pix_acc_r[c] + pix_step_r[c];
            if (eol && !eop) begin
              // row color moves on by twice the row step
              row_acc_r[c] <= row_acc_r[c] + {row_step_r[c][14:0], 1'b0};
            end
          end
          out_eol_r <= eol;
          out_eop_r <= eop;
        end
      end
      S_SETUP: begin
        quo_r <= {div_mag, 8'h00};
        rem_r <= '0;
        neg_r <= div_neg;
      end
      S_ITER: begin
        quo_r <= quo_nxt;
        rem_r <= rem_nxt;
      end
      S_WRITE: begin
        if (job_r == JOB_ROW) begin
          row_step_r[ch_r] <= div_res;
          // a line walks the row step itself
          if (mode_r == MODE_LINE) begin
            pix_step_r[ch_r] <= div_res;
          end
        end else begin
          pix_step_r[ch_r] <= div_res;
          pix_acc_r[ch_r]  <= {row_acc_r[ch_r][15:8], 8'h00};
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------- checks
  `ASSERT_IMPLIES(a_eop_is_eol, clk, rst_n, out_valid_r && out_eop_r, out_eol_r)
  `ASSERT_NEXT(a_next_emits, clk, rst_n, emit, out_valid_r)
  `ASSERT_IMPLIES(a_div_needs_pattern, clk, rst_n, state_r != S_IDLE, active_r && !in_ch.ready)
  `ASSERT_IMPLIES(a_index_in_line, clk, rst_n, active_r, pix_idx_r < size_r)

endmodule
